@@ sv/pwc_pkg.sv @@
// pwc_pkg: constants, payload types and controller/datapath command and
// status structs for the polyline weighted centroid core
// no dependencies
`timescale 1ns / 1ps

package pwc_pkg;

   localparam int MAX_POINTS = 4096;

   localparam int COORD_W    = 24;
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int LEN_W      = 38;
   localparam int WSUM_W     = 64;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int SQ_W       = 2 * DIFF_W;
   localparam int ROOT_W     = SQ_W / 2;
   localparam int REM_W      = ROOT_W + 2;
   localparam int PROD_W     = ROOT_W + 1 + DIFF_W;
   localparam int DEN_W      = LEN_W + 1;
   localparam int SQRT_STEPS = ROOT_W;
   localparam int DIV_STEPS  = WSUM_W;
   localparam int STEP_W     = $clog2(DIV_STEPS);

   localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [1:0] status_type;

   localparam status_type ST_OK       = 2'd0;
   localparam status_type ST_ZERO_LEN = 2'd1;
   localparam status_type ST_OVERFLOW = 2'd2;

   typedef struct packed {
      logic capture;
      logic set_ovf;
      logic take_first;
      logic square;
      logic sqrt_init;
      logic sqrt_step;
      logic mul;
      logic accum;
      logic div_init;
      logic div_step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic count_full;
      logic last;
      logic out_busy;
   } stat_type;

endpackage

@@ sv/pwc_if.sv @@
// pwc_req_if and pwc_rsp_if: valid/ready channels for vertices and results
// depends on pwc_pkg
`timescale 1ns / 1ps

interface pwc_req_if;
   import pwc_pkg::*;

   logic      valid;
   logic      ready;
   coord_type point_x;
   coord_type point_y;
   logic      last_point;

   modport source (output valid, output point_x, output point_y, output last_point,
                   input ready);
   modport sink   (input valid, input point_x, input point_y, input last_point,
                   output ready);
endinterface

interface pwc_rsp_if;
   import pwc_pkg::*;

   logic       valid;
   logic       ready;
   coord_type  center_x;
   coord_type  center_y;
   status_type route_status;

   modport source (output valid, output center_x, output center_y, output route_status,
                   input ready);
   modport sink   (input valid, input center_x, input center_y, input route_status,
                   output ready);
endinterface

@@ sv/polyline_weighted_centroid_core.sv @@
// polyline_weighted_centroid_core: top level, joins controller and datapath
// depends on pwc_pkg, pwc_if, pwc_ctrl, pwc_datapath
`timescale 1ns / 1ps

// usage
//   req_chan carries one route vertex per transaction (point_x, point_y in
//   signed Q15.8, last_point marks the final vertex). rsp_chan carries one
//   transaction per route: length-weighted centroid and route_status.
//   one vertex at a time: req_chan.ready is high only while idle
//   first vertex of a route, or one beyond the point limit: dispatch only
//   any other vertex: square, 25-step bit-serial square root, multiply, add
//   last vertex: then the two 64-step restoring dividers, which
//   run side by side; the result is registered once the output is free
//   the result sits in an output register; vertices of the next route are
//   taken while it waits, and only the next route's final step waits for
//   rsp_chan.ready before the register is overwritten
//   reset (synchronous, active high) clears the route sums, the previous
//   vertex, the point count and the output valid

module polyline_weighted_centroid_core (
   input  logic       clock,
   input  logic       reset,
   pwc_req_if.sink    req_chan,
   pwc_rsp_if.source  rsp_chan
);
   import pwc_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   pwc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pwc_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_point_x      (req_chan.point_x),
      .req_point_y      (req_chan.point_y),
      .req_last_point   (req_chan.last_point),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_center_x     (rsp_chan.center_x),
      .rsp_center_y     (rsp_chan.center_y),
      .rsp_route_status (rsp_chan.route_status)
   );

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("vertex accepted while previous one still in work");

   a_zero_len_center: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.route_status == ST_ZERO_LEN
      |-> rsp_chan.center_x == '0 && rsp_chan.center_y == '0)
      else $error("zero length route with nonzero centroid");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.route_status != 2'd3)
      else $error("undefined route status");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !stat.out_busy)
      else $error("result register overwritten while held");

endmodule

@@ sv/pwc_ctrl.sv @@
// pwc_ctrl: sequencer for one vertex and the end-of-route division
// depends on pwc_pkg
`timescale 1ns / 1ps

module pwc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pwc_pkg::stat_type stat,
   output pwc_pkg::cmd_type  cmd
);
   import pwc_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_SQUARE,
      S_SQRT_INIT,
      S_SQRT,
      S_MUL,
      S_ACCUM,
      S_DIV_INIT,
      S_DIV,
      S_EMIT
   } state_type;

   state_type          state_ff, state_in;
   logic [STEP_W-1:0]  step_ff, step_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (stat.count_full) begin
               cmd.set_ovf = 1'b1;
               state_in    = stat.last ? S_DIV_INIT : S_IDLE;
            end else if (stat.count_zero) begin
               cmd.take_first = 1'b1;
               state_in       = stat.last ? S_DIV_INIT : S_IDLE;
            end else begin
               state_in = S_SQUARE;
            end
         end
         S_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = S_SQRT_INIT;
         end
         S_SQRT_INIT: begin
            cmd.sqrt_init = 1'b1;
            step_in       = '0;
            state_in      = S_SQRT;
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (step_ff == STEP_W'(SQRT_STEPS - 1)) begin
               step_in  = '0;
               state_in = S_MUL;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_ACCUM;
         end
         S_ACCUM: begin
            cmd.accum = 1'b1;
            state_in  = stat.last ? S_DIV_INIT : S_IDLE;
         end
         S_DIV_INIT: begin
            cmd.div_init = 1'b1;
            step_in      = '0;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               step_in  = '0;
               state_in = S_EMIT;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_EMIT: begin
            if (!stat.out_busy) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

@@ sv/pwc_datapath.sv @@
// pwc_datapath: route accumulators, bit-serial square root, segment
// multipliers, two restoring dividers and the result register
// depends on pwc_pkg
`timescale 1ns / 1ps

module pwc_datapath (
   input  logic                clock,
   input  logic                reset,
   input  pwc_pkg::cmd_type    cmd,
   output pwc_pkg::stat_type   stat,
   input  pwc_pkg::coord_type  req_point_x,
   input  pwc_pkg::coord_type  req_point_y,
   input  logic                req_last_point,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output pwc_pkg::coord_type  rsp_center_x,
   output pwc_pkg::coord_type  rsp_center_y,
   output pwc_pkg::status_type rsp_route_status
);
   import pwc_pkg::*;

   // route state
   coord_type          prev_x_ff, prev_x_in;
   coord_type          prev_y_ff, prev_y_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [WSUM_W-1:0]  wsx_ff, wsx_in;
   logic [WSUM_W-1:0]  wsy_ff, wsy_in;
   logic               ovf_ff, ovf_in;
   logic               valid_ff, valid_in;

   // per-vertex work registers
   coord_type                 x_ff, y_ff;
   logic                      last_ff;
   logic signed [DIFF_W-1:0]  dx_ff, dy_ff;
   logic signed [SQ_W-1:0]    sqx_ff, sqy_ff;
   logic [SQ_W-1:0]           rad_ff;
   logic [REM_W-1:0]          srem_ff;
   logic [ROOT_W-1:0]         root_ff;
   logic signed [PROD_W-1:0]  px_ff, py_ff;

   // division registers
   logic [WSUM_W-1:0]  numx_ff, numy_ff;
   logic [DEN_W-1:0]   remx_ff, remy_ff;
   logic [DEN_W-1:0]   den_ff;
   logic               negx_ff, negy_ff;

   coord_type   center_x_ff, center_y_ff;
   status_type  status_ff;

   logic [REM_W+1:0]           srem_sh;
   logic [REM_W+1:0]           trial;
   logic signed [DIFF_W-1:0]   sumx, sumy;
   logic [WSUM_W-1:0]          magx, magy;
   logic [DEN_W+WSUM_W-1:0]    divx_nxt, divy_nxt;
   logic                       len_zero;

   function automatic logic [DEN_W+WSUM_W-1:0] div_step(
      input logic [DEN_W-1:0]  rem,
      input logic [WSUM_W-1:0] num,
      input logic [DEN_W-1:0]  den
   );
      logic [DEN_W:0] sh;
      logic           ge;
      sh = {rem, num[WSUM_W-1]};
      ge = (sh >= {1'b0, den});
      if (ge) begin
         sh = sh - {1'b0, den};
      end
      return {sh[DEN_W-1:0], num[WSUM_W-2:0], ge};
   endfunction

   function automatic coord_type saturate(input logic neg, input logic [WSUM_W-1:0] q);
      coord_type r;
      if (neg) begin
         if (q > WSUM_W'(2 ** (COORD_W - 1))) begin
            r = COORD_MIN;
         end else begin
            r = -coord_type'(q[COORD_W-1:0]);
         end
      end else begin
         if (q > WSUM_W'(2 ** (COORD_W - 1) - 1)) begin
            r = COORD_MAX;
         end else begin
            r = coord_type'(q[COORD_W-1:0]);
         end
      end
      return r;
   endfunction

   assign len_zero = (len_ff == '0);

   assign stat.count_zero = (count_ff == '0);
   assign stat.count_full = (count_ff == CNT_W'(MAX_POINTS));
   assign stat.last       = last_ff;
   assign stat.out_busy   = valid_ff & ~rsp_ready;

   assign srem_sh = {srem_ff, rad_ff[SQ_W-1 -: 2]};
   assign trial   = {2'b00, root_ff, 2'b01};

   assign sumx = DIFF_W'(x_ff) + DIFF_W'(prev_x_ff);
   assign sumy = DIFF_W'(y_ff) + DIFF_W'(prev_y_ff);

   assign magx = wsx_ff[WSUM_W-1] ? (~wsx_ff + 1'b1) : wsx_ff;
   assign magy = wsy_ff[WSUM_W-1] ? (~wsy_ff + 1'b1) : wsy_ff;

   assign divx_nxt = div_step(remx_ff, numx_ff, den_ff);
   assign divy_nxt = div_step(remy_ff, numy_ff, den_ff);

   always_comb begin
      prev_x_in = prev_x_ff;
      prev_y_in = prev_y_ff;
      count_in  = count_ff;
      len_in    = len_ff;
      wsx_in    = wsx_ff;
      wsy_in    = wsy_ff;
      ovf_in    = ovf_ff;
      valid_in  = valid_ff & ~rsp_ready;
      if (cmd.set_ovf) begin
         ovf_in = 1'b1;
      end
      if (cmd.take_first || cmd.accum) begin
         prev_x_in = x_ff;
         prev_y_in = y_ff;
         count_in  = count_ff + 1'b1;
      end
      if (cmd.accum) begin
         len_in = len_ff + LEN_W'(root_ff);
         wsx_in = wsx_ff + WSUM_W'(px_ff);
         wsy_in = wsy_ff + WSUM_W'(py_ff);
      end
      if (cmd.emit) begin
         prev_x_in = '0;
         prev_y_in = '0;
         count_in  = '0;
         len_in    = '0;
         wsx_in    = '0;
         wsy_in    = '0;
         ovf_in    = 1'b0;
         valid_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_x_ff <= '0;
         prev_y_ff <= '0;
         count_ff  <= '0;
         len_ff    <= '0;
         wsx_ff    <= '0;
         wsy_ff    <= '0;
         ovf_ff    <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         prev_x_ff <= prev_x_in;
         prev_y_ff <= prev_y_in;
         count_ff  <= count_in;
         len_ff    <= len_in;
         wsx_ff    <= wsx_in;
         wsy_ff    <= wsy_in;
         ovf_ff    <= ovf_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x_ff    <= req_point_x;
         y_ff    <= req_point_y;
         last_ff <= req_last_point;
         dx_ff   <= DIFF_W'(req_point_x) - DIFF_W'(prev_x_ff);
         dy_ff   <= DIFF_W'(req_point_y) - DIFF_W'(prev_y_ff);
      end
      if (cmd.square) begin
         sqx_ff <= dx_ff * dx_ff;
         sqy_ff <= dy_ff * dy_ff;
      end
      if (cmd.sqrt_init) begin
         rad_ff  <= $unsigned(sqx_ff) + $unsigned(sqy_ff);
         srem_ff <= '0;
         root_ff <= '0;
      end
      if (cmd.sqrt_step) begin
         rad_ff <= {rad_ff[SQ_W-3:0], 2'b00};
         if (srem_sh >= trial) begin
            srem_ff <= REM_W'(srem_sh - trial);
            root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            srem_ff <= srem_sh[REM_W-1:0];
            root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
      if (cmd.mul) begin
         px_ff <= $signed({1'b0, root_ff}) * sumx;
         py_ff <= $signed({1'b0, root_ff}) * sumy;
      end
      if (cmd.div_init) begin
         numx_ff <= magx + WSUM_W'(len_ff);
         numy_ff <= magy + WSUM_W'(len_ff);
         negx_ff <= wsx_ff[WSUM_W-1];
         negy_ff <= wsy_ff[WSUM_W-1];
         remx_ff <= '0;
         remy_ff <= '0;
         den_ff  <= {len_ff, 1'b0};
      end
      if (cmd.div_step) begin
         {remx_ff, numx_ff} <= divx_nxt;
         {remy_ff, numy_ff} <= divy_nxt;
      end
      if (cmd.emit) begin
         center_x_ff <= len_zero ? '0 : saturate(negx_ff, numx_ff);
         center_y_ff <= len_zero ? '0 : saturate(negy_ff, numy_ff);
         if (ovf_ff) begin
            status_ff <= ST_OVERFLOW;
         end else if (len_zero) begin
            status_ff <= ST_ZERO_LEN;
         end else begin
            status_ff <= ST_OK;
         end
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_center_x     = center_x_ff;
   assign rsp_center_y     = center_y_ff;
   assign rsp_route_status = status_ff;

endmodule

@@ sim/tb_polyline_weighted_centroid_core.sv @@
// tb_polyline_weighted_centroid_core: self-checking testbench for the route centroid core
// a scoreboard class predicts each route's centroid and status; routes are random
// and directed, with sender bursts and receiver stalls. depends on pwc_pkg, pwc_if and the core
`timescale 1ns / 1ps

module tb_polyline_weighted_centroid_core;
   import pwc_pkg::*;

   typedef struct packed {
      coord_type  cx;
      coord_type  cy;
      status_type status;
   } centroid_type;

   class centroid_scoreboard;
      centroid_type    pending[$];
      int unsigned     errors;
      coord_type       last_x;
      coord_type       last_y;
      int unsigned     vertex_count;
      bit [LEN_W-1:0]  length_total;
      bit [WSUM_W-1:0] moment_x;
      bit [WSUM_W-1:0] moment_y;
      bit              limit_hit;

      function new();
         errors = 0;
         start_route();
      endfunction

      function void start_route();
         last_x = '0;
         last_y = '0;
         vertex_count = 0;
         length_total = '0;
         moment_x = '0;
         moment_y = '0;
         limit_hit = 1'b0;
      endfunction

      function bit [63:0] floor_sqrt(bit [63:0] v);
         bit [63:0] root;
         bit [63:0] trial;
         root = '0;
         for (int i = 31; i >= 0; i--) begin
            trial = root | (64'd1 << i);
            if (trial * trial <= v) root = trial;
         end
         return root;
      endfunction

      // mean of midpoints, ties away from zero, saturated to the coordinate range
      function coord_type rounded_mean(bit [63:0] moment, bit [63:0] den);
         bit        neg;
         bit [63:0] mag;
         bit [63:0] q;
         bit [63:0] nq;
         neg = moment[63];
         mag = neg ? (64'd0 - moment) : moment;
         q = (mag + den / 2) / den;
         if (neg) begin
            if (q > 64'd8388608) return COORD_MIN;
            nq = 64'd0 - q;
            return nq[COORD_W-1:0];
         end
         if (q > 64'd8388607) return COORD_MAX;
         return q[COORD_W-1:0];
      endfunction

      function void note_vertex(coord_type x, coord_type y, logic last);
         longint       dx;
         longint       dy;
         bit [63:0]    seg;
         centroid_type want;
         if (vertex_count >= MAX_POINTS) begin
            limit_hit = 1'b1;
         end else begin
            if (vertex_count != 0) begin
               dx = longint'(x) - longint'(last_x);
               dy = longint'(y) - longint'(last_y);
               seg = floor_sqrt(dx * dx + dy * dy);
               length_total += seg[LEN_W-1:0];
               moment_x += seg * (longint'(x) + longint'(last_x));
               moment_y += seg * (longint'(y) + longint'(last_y));
            end
            last_x = x;
            last_y = y;
            vertex_count++;
         end
         if (last) begin
            want.cx = '0;
            want.cy = '0;
            want.status = ST_ZERO_LEN;
            if (length_total != 0) begin
               want.cx = rounded_mean(moment_x, {length_total, 1'b0});
               want.cy = rounded_mean(moment_y, {length_total, 1'b0});
               want.status = ST_OK;
            end
            if (limit_hit) want.status = ST_OVERFLOW;
            pending.insert(pending.size(), want);
            start_route();
         end
      endfunction

      function void check_centroid(coord_type cx, coord_type cy, status_type st);
         centroid_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result center_x %0d center_y %0d route_status %0d",
                     $time, cx, cy, st);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (cx !== want.cx) begin
            $display("%0t: center_x expected %0d actual %0d", $time, want.cx, cx);
            errors++;
         end
         if (cy !== want.cy) begin
            $display("%0t: center_y expected %0d actual %0d", $time, want.cy, cy);
            errors++;
         end
         if (st !== want.status) begin
            $display("%0t: route_status expected %0d actual %0d", $time, want.status, st);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   pwc_req_if req_chan ();
   pwc_rsp_if rsp_chan ();

   polyline_weighted_centroid_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   centroid_scoreboard book;
   int unsigned        burst_left = 0;
   int unsigned        random_items = 0;
   logic [15:0]        stall_tick = '0;
   int unsigned        stall_mode = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // receiver stall pattern, mode is redrawn whenever the low byte of stall_tick is zero
   always @(posedge clock) begin
      stall_tick <= stall_tick + 16'd1;
      if (stall_tick[7:0] == 8'd0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_chan.ready <= 1'b1;
         1: rsp_chan.ready <= 1'($urandom_range(0, 1));
         2: rsp_chan.ready <= (stall_tick[1:0] == 2'd0);
         default: rsp_chan.ready <= (stall_tick[7:0] > 8'd220);
      endcase
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready)
            book.check_centroid(rsp_chan.center_x, rsp_chan.center_y, rsp_chan.route_status);
         if (req_chan.valid && req_chan.ready)
            book.note_vertex(req_chan.point_x, req_chan.point_y, req_chan.last_point);
      end
   end

   task automatic send_vertex(input coord_type x, input coord_type y, input logic last);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         case ($urandom_range(0, 9))
            0, 1, 2: gap = 0;
            3, 4, 5, 6, 7: gap = $urandom_range(1, 40);
            default: gap = $urandom_range(41, 100);
         endcase
         if (gap != 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_chan.valid <= 1'b1;
      req_chan.point_x <= x;
      req_chan.point_y <= y;
      req_chan.last_point <= last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   function automatic coord_type corner_value();
      case ($urandom_range(0, 4))
         0: return COORD_MIN;
         1: return COORD_MAX;
         2: return '0;
         3: return -24'sd1;
         default: return 24'sd1;
      endcase
   endfunction

   task automatic random_route();
      int unsigned len;
      int unsigned style;
      int          base_x;
      int          base_y;
      coord_type   x;
      coord_type   y;
      case ($urandom_range(0, 9))
         0: len = 1;
         1, 2, 3, 4, 5, 6: len = $urandom_range(2, 6);
         default: len = $urandom_range(7, 30);
      endcase
      style = $urandom_range(0, 4);
      base_x = $urandom;
      base_y = $urandom;
      x = coord_type'(base_x);
      y = coord_type'(base_y);
      for (int i = 0; i < len; i++) begin
         case (style)
            0: begin
               x = coord_type'($urandom);
               y = coord_type'($urandom);
            end
            1: begin
               x = coord_type'(base_x + int'($urandom_range(0, 1023)) - 512);
               y = coord_type'(base_y + int'($urandom_range(0, 1023)) - 512);
            end
            2: begin
               x = corner_value();
               y = corner_value();
            end
            3: ;
            default: begin
               x = x + coord_type'($urandom_range(0, 64)) - 24'sd32;
               y = y + coord_type'($urandom_range(0, 64)) - 24'sd32;
            end
         endcase
         send_vertex(x, y, i == len - 1);
      end
      random_items += len;
   endtask

   initial begin
      book = new();
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.point_x <= '0;
      req_chan.point_y <= '0;
      req_chan.last_point <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // single point
      send_vertex(COORD_MAX, COORD_MIN, 1'b1);
      // longest segments
      send_vertex(COORD_MIN, COORD_MIN, 1'b0);
      send_vertex(COORD_MAX, COORD_MAX, 1'b1);
      send_vertex(COORD_MAX, COORD_MIN, 1'b0);
      send_vertex(COORD_MIN, COORD_MAX, 1'b1);
      // zero length route, then an axis-aligned route
      send_vertex('0, '0, 1'b0);
      send_vertex('0, '0, 1'b1);
      send_vertex('0, '0, 1'b0);
      send_vertex(24'sd256, '0, 1'b0);
      send_vertex(24'sd256, 24'sd2560, 1'b1);
      // rounding ties on both signs
      send_vertex(-24'sd1, '0, 1'b0);
      send_vertex(-24'sd2, '0, 1'b1);
      send_vertex(24'sd1, '0, 1'b0);
      send_vertex(24'sd2, '0, 1'b1);
      send_vertex(24'h555555, 24'hAAAAAA, 1'b0);
      send_vertex(24'hAAAAAA, 24'h555555, 1'b1);
      // repeated vertex inside a route
      send_vertex(24'sd10, 24'sd10, 1'b0);
      send_vertex(24'sd10, 24'sd10, 1'b0);
      send_vertex(24'sd20, 24'sd10, 1'b1);

      while (random_items < 930) random_route();

      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (book.pending.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      if (book.errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
